// ===== rtl/pccmr_pkg.sv =====
package pccmr_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned PageW  = 23;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned RightW = 3;
  localparam int unsigned WidxW  = 10;

  // Input word kinds.
  localparam logic [1:0] KIND_ADJUST = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_CONTIG = 2'd2;

  // Result actions.
  localparam logic [2:0] ACT_COMMIT   = 3'd0;
  localparam logic [2:0] ACT_DECOMMIT = 3'd1;
  localparam logic [2:0] ACT_MAP      = 3'd2;
  localparam logic [2:0] ACT_UNMAP    = 3'd3;
  localparam logic [2:0] ACT_ERROR    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_PAGE_SHIFT   = 2'd0;
  localparam logic [1:0] REG_PROCESS_BASE = 2'd1;
  localparam logic [1:0] REG_HOST_BASE    = 2'd2;
  localparam logic [1:0] REG_RIGHTS       = 2'd3;

  localparam logic [ShiftW-1:0] ShiftMin   = 5'd10;
  localparam logic [ShiftW-1:0] ShiftMax   = 5'd16;
  localparam logic [ShiftW-1:0] ShiftReset = 5'd12;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] new_bottom;
    logic [AddrW-1:0] new_top;
    logic [WidxW-1:0] word_index;
    logic [31:0]      word_bits;
    logic             do_map;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [AddrW-1:0]  guest_address;
    logic [AddrW-1:0]  host_address;
    logic [AddrW-1:0]  byte_length;
    logic [RightW-1:0] rights;
    logic              last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic calc_adj;
    logic emit_top;
    logic emit_bot;
    logic emit_run;
    logic emit_contig;
    logic emit_err;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       word_oob;
    logic       base_zero;
    logic       word_zero;
    logic       top_ne;
    logic       bot_ne;
    logic       run_last;
    logic       rng_ready;
  } dp_status_t;

  // Count of trailing zeros by a five-step binary search; 32 for zero.
  function automatic logic [5:0] ctz32(input logic [31:0] v);
    logic [31:0] t;
    logic [5:0]  n;
    t = v;
    n = 6'd0;
    if (v == 32'd0) begin
      n = 6'd32;
    end else begin
      for (int k = 4; k >= 0; k--) begin
        if ((t & ((32'd1 << (1 << k)) - 32'd1)) == 32'd0) begin
          n = n + 6'(1 << k);
          t = t >> (1 << k);
        end
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/pccmr_ctrl.sv =====
module pccmr_ctrl
  import pccmr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_ADJ_TOP  = 3'd2;
  localparam logic [2:0] ST_ADJ_BOT  = 3'd3;
  localparam logic [2:0] ST_RUNS     = 3'd4;
  localparam logic [2:0] ST_CONTIG   = 3'd5;
  localparam logic [2:0] ST_ERROR    = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.kind)
          KIND_ADJUST: begin
            cmd_o.calc_adj = 1'b1;
            state_d = ST_ADJ_TOP;
          end
          KIND_WORD: begin
            if (status_i.word_oob) begin
              state_d = ST_IDLE;
            end else if (status_i.base_zero) begin
              state_d = ST_ERROR;
            end else if (status_i.word_zero) begin
              state_d = ST_IDLE;
            end else begin
              state_d = ST_RUNS;
            end
          end
          KIND_CONTIG: begin
            state_d = status_i.base_zero ? ST_ERROR : ST_CONTIG;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_ADJ_TOP: begin
        if (!status_i.top_ne || status_i.rng_ready) begin
          cmd_o.emit_top = 1'b1;
          state_d = status_i.bot_ne ? ST_ADJ_BOT : ST_IDLE;
        end
      end
      ST_ADJ_BOT: begin
        if (status_i.rng_ready) begin
          cmd_o.emit_bot = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RUNS: begin
        if (status_i.rng_ready) begin
          cmd_o.emit_run = 1'b1;
          if (status_i.run_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CONTIG: begin
        if (status_i.rng_ready) begin
          cmd_o.emit_contig = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (status_i.rng_ready) begin
          cmd_o.emit_err = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/pccmr_datapath.sv =====
module pccmr_datapath
  import pccmr_pkg::*;
#(
  parameter int unsigned BITMAP_WORDS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [AddrW-1:0]  cfg_wdata_i,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o
);

  // Configuration registers.
  logic [ShiftW-1:0] page_shift_q;
  logic [AddrW-1:0]  process_base_q;
  logic [AddrW-1:0]  host_base_q;
  logic [RightW-1:0] rights_q;

  // Window state.
  logic [PageW-1:0] top_q, bottom_q;

  // Item registers.
  in_word_t         item_q;
  logic [31:0]      word_q;
  logic [PageW-1:0] tp_q, bp_q;

  // Range stage.
  logic             rng_vld_q;
  logic [2:0]       rng_act_q;
  logic [PageW-1:0] rng_start_q;
  logic [AddrW-1:0] rng_count_q;
  logic             rng_last_q;

  // Output stage.
  logic      out_vld_q;
  out_word_t out_q;

  logic [ShiftW-1:0] sh;
  logic [32:0]       top_sum;
  logic [PageW-1:0]  tp_calc, bp_calc;
  logic              top_ne, bot_ne;
  logic [PageW-1:0]  top_lo, top_hi, bot_lo, bot_hi;
  logic [31:0]       low_bit, run_rest;
  logic [32:0]       run_sum;
  logic [5:0]        run_s, run_e;
  logic [PageW-1:0]  run_start;
  logic [2:0]        map_act;
  logic              out_load, rng_load;
  logic [AddrW-1:0]  off, len;

  always_comb begin
    if (page_shift_q < ShiftMin) begin
      sh = ShiftMin;
    end else if (page_shift_q > ShiftMax) begin
      sh = ShiftMax;
    end else begin
      sh = page_shift_q;
    end
  end

  // New top rounds up, new bottom rounds down.
  assign top_sum = {1'b0, item_q.new_top} + ((33'd1 << sh) - 33'd1);
  assign tp_calc = PageW'(top_sum >> sh);
  assign bp_calc = PageW'(item_q.new_bottom >> sh);

  assign top_ne = (tp_q != top_q);
  assign bot_ne = (item_q.new_bottom != {AddrW{1'b1}}) && (bp_q != bottom_q);
  assign top_lo = (tp_q < top_q) ? tp_q : top_q;
  assign top_hi = (tp_q < top_q) ? top_q : tp_q;
  assign bot_lo = (bp_q < bottom_q) ? bp_q : bottom_q;
  assign bot_hi = (bp_q < bottom_q) ? bottom_q : bp_q;

  // Lowest run of set bits: adding its lowest bit carries through the run.
  assign low_bit   = word_q & (~word_q + 32'd1);
  assign run_sum   = {1'b0, word_q} + {1'b0, low_bit};
  assign run_s     = ctz32(word_q);
  assign run_e     = ctz32(run_sum[31:0]);
  assign run_rest  = word_q & run_sum[31:0];
  assign run_start = PageW'({item_q.word_index, run_s[4:0]});
  assign map_act   = item_q.do_map ? ACT_MAP : ACT_UNMAP;

  assign out_load = rng_vld_q && (!out_vld_q || !out_stall_i);
  assign rng_load = (cmd_i.emit_top && top_ne) || cmd_i.emit_bot || cmd_i.emit_run
                    || cmd_i.emit_contig || cmd_i.emit_err;

  assign status_o.kind      = item_q.kind;
  assign status_o.word_oob  = (32'(item_q.word_index) >= 32'(BITMAP_WORDS));
  assign status_o.base_zero = (process_base_q == '0);
  assign status_o.word_zero = (word_q == 32'd0);
  assign status_o.top_ne    = top_ne;
  assign status_o.bot_ne    = bot_ne;
  assign status_o.run_last  = (run_rest == 32'd0);
  assign status_o.rng_ready = !rng_vld_q || !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q   <= ShiftReset;
      process_base_q <= '0;
      host_base_q    <= '0;
      rights_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PAGE_SHIFT:   page_shift_q   <= cfg_wdata_i[ShiftW-1:0];
        REG_PROCESS_BASE: process_base_q <= cfg_wdata_i;
        REG_HOST_BASE:    host_base_q    <= cfg_wdata_i;
        REG_RIGHTS:       rights_q       <= cfg_wdata_i[RightW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      bottom_q <= '0;
    end else begin
      if (cmd_i.emit_top) begin
        top_q <= tp_q;
      end
      if (cmd_i.emit_bot) begin
        bottom_q <= bp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_word_i;
      word_q <= in_word_i.word_bits;
    end else if (cmd_i.emit_run) begin
      word_q <= run_rest;
    end
    if (cmd_i.calc_adj) begin
      tp_q <= tp_calc;
      bp_q <= bp_calc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_vld_q <= 1'b0;
    end else if (rng_load) begin
      rng_vld_q <= 1'b1;
    end else if (out_load) begin
      rng_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rng_load) begin
      if (cmd_i.emit_top) begin
        rng_act_q   <= (tp_q < top_q) ? ACT_DECOMMIT : ACT_COMMIT;
        rng_start_q <= top_lo;
        rng_count_q <= AddrW'(top_hi - top_lo);
        rng_last_q  <= !bot_ne;
      end else if (cmd_i.emit_bot) begin
        rng_act_q   <= (bp_q > bottom_q) ? ACT_DECOMMIT : ACT_COMMIT;
        rng_start_q <= bot_lo;
        rng_count_q <= AddrW'(bot_hi - bot_lo);
        rng_last_q  <= 1'b1;
      end else if (cmd_i.emit_run) begin
        rng_act_q   <= map_act;
        rng_start_q <= run_start;
        rng_count_q <= AddrW'(run_e - run_s);
        rng_last_q  <= (run_rest == 32'd0);
      end else if (cmd_i.emit_contig) begin
        rng_act_q   <= map_act;
        rng_start_q <= bottom_q;
        rng_count_q <= AddrW'(top_q) - AddrW'(bottom_q);
        rng_last_q  <= 1'b1;
      end else begin
        rng_act_q   <= ACT_ERROR;
        rng_start_q <= '0;
        rng_count_q <= '0;
        rng_last_q  <= 1'b1;
      end
    end
  end

  assign off = AddrW'(rng_start_q) << sh;
  assign len = rng_count_q << sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.action        <= rng_act_q;
      out_q.last          <= rng_last_q;
      out_q.byte_length   <= len;
      out_q.host_address  <= '0;
      out_q.rights        <= '0;
      case (rng_act_q)
        ACT_COMMIT, ACT_DECOMMIT: begin
          out_q.guest_address <= off;
        end
        ACT_MAP: begin
          out_q.guest_address <= process_base_q + off;
          out_q.host_address  <= host_base_q + off;
          out_q.rights        <= rights_q;
        end
        ACT_UNMAP: begin
          out_q.guest_address <= process_base_q + off;
        end
        default: begin
          out_q.guest_address <= '0;
          out_q.byte_length   <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/page_chunk_commit_and_map_runs_core.sv =====
// Channel   Direction  Handshake               Word
// in        input      in_valid_i / in_stall_o  in_word_t: kind, window, bitmap word
// out       output     out_valid_o / out_stall_i out_word_t: one range or an error
// cfg       input      cfg_we_i                 cfg_index_i selects, cfg_wdata_i data
//
// An input word is loaded and dispatched on its kind; then its results are
// formed in turn: an adjust word gives up to two ranges, a bitmap word one
// per run of set bits (at most 16), a contiguous or error word one. The run
// finder in the datapath produces one run per cycle while the range stage
// can take it, and sets the pace. Results go through a range stage and an
// output register. Reset clears the window to zero and the registers to
// their defaults. A stall on the output backs up into the range stage and
// holds the controller; a new input word is taken while results still wait.
module page_chunk_commit_and_map_runs_core
  import pccmr_pkg::*;
#(
  parameter int unsigned BITMAP_WORDS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [AddrW-1:0] cfg_wdata_i
);

  // The controller steps through the phases of each word; the datapath holds
  // the window, the configuration, the run finder and the two result stages.
  dp_cmd_t    cmd;
  dp_status_t status;

  pccmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pccmr_datapath #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== rtl/pccmr_checker.sv =====
module pccmr_checker
  import pccmr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input in_word_t         in_word_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_word_t        out_word_o,
  input logic             cfg_we_i,
  input logic [1:0]       cfg_index_i,
  input logic [AddrW-1:0] cfg_wdata_i
);

  // One word at a time: the input closes right after an accept.
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a word is in progress");

  // Error results carry nothing but the action and the last mark.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.action == ACT_ERROR |->
      out_word_o.last && out_word_o.guest_address == '0 &&
      out_word_o.host_address == '0 && out_word_o.byte_length == '0)
    else $error("malformed error result");

  // Only map ranges carry a host address or rights.
  a_nonmap_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.action != ACT_MAP |->
      out_word_o.host_address == '0 && out_word_o.rights == '0)
    else $error("host address or rights on a non-map result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

endmodule

bind page_chunk_commit_and_map_runs_core pccmr_checker u_pccmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_index_i (cfg_index_i),
  .cfg_wdata_i (cfg_wdata_i)
);

// ===== tb/page_chunk_commit_and_map_runs_core_tb.sv =====
`timescale 1ns / 1ps

module page_chunk_commit_and_map_runs_core_tb;
  import pccmr_pkg::*;

  // The one kind code that the block must ignore.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Bitmap size of the instance, matching the block's default.
  localparam int unsigned WordCount = 1024;
  // Cycles allowed after the last expected range before the block counts as
  // idle. An adjust word that changes nothing leaves no trace, so this must
  // cover its controller pass as well as the two-stage output path.
  localparam int unsigned SettleCycles = 40;
  // Run limit in cycles. The slowest correct run is about 105 words, each with
  // up to 16 ranges that each may sit out an output stall, well below this.
  localparam int unsigned CycleLimit = 400000;

  logic      clk;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  in_word_t  in_word = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_PAGE_SHIFT;
  logic [31:0] cfg_wdata = '0;

  page_chunk_commit_and_map_runs_core #(
    .BITMAP_WORDS(WordCount)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow copy of the configuration registers, as last written.
  logic [4:0]  shadow_shift = ShiftReset;
  logic [31:0] shadow_proc_base = '0;
  logic [31:0] shadow_host_base = '0;
  logic [2:0]  shadow_rights = '0;

  // Shadow copy of the committed window, in pages.
  logic [PageW-1:0] win_bottom_page = '0;
  logic [PageW-1:0] win_top_page = '0;

  // Ranges predicted for accepted words, oldest first.
  out_word_t pending_ranges[$];

  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  // When clear, neither side inserts gaps; the last phase runs this way.
  bit          idle_en = 1'b1;
  int unsigned stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung block or a lost range ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t ns: timeout with %0d ranges outstanding", $time, pending_ranges.size());
      $display("[page_chunk_commit_and_map_runs_core] ERROR");
      $finish;
    end
  end

  // Page shift as the block applies it: anything outside 10..16 is clamped.
  function automatic int unsigned applied_shift();
    if (shadow_shift < ShiftMin) return ShiftMin;
    if (shadow_shift > ShiftMax) return ShiftMax;
    return shadow_shift;
  endfunction

  // A commit or decommit range of the window, in plain chunk offsets.
  function automatic out_word_t window_range(input logic [2:0] act, input logic [63:0] page,
                                             input logic [63:0] count, input int unsigned sh);
    out_word_t   r;
    logic [63:0] start_b;
    logic [63:0] len_b;
    start_b = page << sh;
    len_b = count << sh;
    r = '0;
    r.action = act;
    r.guest_address = start_b[31:0];
    r.byte_length = len_b[31:0];
    return r;
  endfunction

  // A map or unmap range; offsets are relocated to the guest and host bases.
  function automatic out_word_t mapping_range(input logic do_map, input logic [63:0] page,
                                              input logic [63:0] count, input int unsigned sh);
    out_word_t   r;
    logic [63:0] off_b;
    logic [63:0] len_b;
    off_b = page << sh;
    len_b = count << sh;
    r = '0;
    r.guest_address = shadow_proc_base + off_b[31:0];
    r.byte_length = len_b[31:0];
    if (do_map) begin
      r.action = ACT_MAP;
      r.host_address = shadow_host_base + off_b[31:0];
      r.rights = shadow_rights;
    end else begin
      r.action = ACT_UNMAP;
    end
    return r;
  endfunction

  // Works out the ranges that one accepted word causes, updates the shadow
  // window and queues the ranges in order with the final one flagged.
  task automatic predict_ranges(input in_word_t w);
    out_word_t   found[$];
    out_word_t   err_word;
    int unsigned sh;
    logic [63:0] tp;
    logic [63:0] bp;
    int unsigned b;
    int unsigned s;
    sh = applied_shift();
    case (w.kind)
      KIND_ADJUST: begin
        // The top rounds up and the bottom rounds down to whole pages.
        tp = ((64'(w.new_top) + (64'd1 << sh) - 64'd1) >> sh) & 64'h7F_FFFF;
        bp = (64'(w.new_bottom) >> sh) & 64'h7F_FFFF;
        if (tp < win_top_page) begin
          found.push_back(window_range(ACT_DECOMMIT, tp, 64'(win_top_page) - tp, sh));
        end else if (tp > win_top_page) begin
          found.push_back(window_range(ACT_COMMIT, 64'(win_top_page),
                                       tp - 64'(win_top_page), sh));
        end
        win_top_page = tp[PageW-1:0];
        // A bottom of all ones leaves the bottom page where it is.
        if (w.new_bottom != '1) begin
          if (bp > win_bottom_page) begin
            found.push_back(window_range(ACT_DECOMMIT, 64'(win_bottom_page),
                                         bp - 64'(win_bottom_page), sh));
          end else if (bp < win_bottom_page) begin
            found.push_back(window_range(ACT_COMMIT, bp, 64'(win_bottom_page) - bp, sh));
          end
          win_bottom_page = bp[PageW-1:0];
        end
      end
      KIND_WORD, KIND_CONTIG: begin
        if (!(w.kind == KIND_WORD && w.word_index >= WordCount)) begin
          if (shadow_proc_base == '0) begin
            err_word = '0;
            err_word.action = ACT_ERROR;
            found.push_back(err_word);
          end else if (w.kind == KIND_CONTIG) begin
            // Top below bottom wraps the page count to 32 bits.
            found.push_back(mapping_range(w.do_map, 64'(win_bottom_page),
                                          (64'(win_top_page) - 64'(win_bottom_page))
                                          & 64'hFFFF_FFFF, sh));
          end else begin
            // One range per run of set bits, lowest bit first; a run that
            // touches bit 31 closes at the end of the word.
            b = 0;
            while (b < 32) begin
              if (w.word_bits[b]) begin
                s = b;
                while (b < 32 && w.word_bits[b]) b++;
                found.push_back(mapping_range(w.do_map, 64'(w.word_index) * 32 + s,
                                              64'(b - s), sh));
              end else begin
                b++;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) pending_ranges.push_back(found[i]);
  endtask

  // Offers one word, optionally after a random gap, and predicts its ranges
  // at the edge where it is taken. Valid stays high afterward so that a
  // following word can go out back to back; the gap or the drain lowers it.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predict_ranges(w);
  endtask

  // Stops offering words and waits until every predicted range has come out
  // and the block has had time to finish a word that causes no range.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes one register and mirrors it. The enable drops for a cycle after
  // each write so that back-to-back writes never reassign it in one step.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PAGE_SHIFT:   shadow_shift = value[4:0];
      REG_PROCESS_BASE: shadow_proc_base = value;
      REG_HOST_BASE:    shadow_host_base = value;
      REG_RIGHTS:       shadow_rights = value[2:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  function automatic in_word_t adjust_word(input logic [31:0] top, input logic [31:0] bottom);
    in_word_t w;
    w = '0;
    w.kind = KIND_ADJUST;
    w.new_top = top;
    w.new_bottom = bottom;
    return w;
  endfunction

  function automatic in_word_t bitmap_word(input logic [9:0] idx, input logic [31:0] bits,
                                           input logic do_map);
    in_word_t w;
    w = '0;
    w.kind = KIND_WORD;
    w.word_index = idx;
    w.word_bits = bits;
    w.do_map = do_map;
    return w;
  endfunction

  function automatic in_word_t contig_word(input logic do_map);
    in_word_t w;
    w = '0;
    w.kind = KIND_CONTIG;
    w.do_map = do_map;
    return w;
  endfunction

  // Compares one field of a range and logs it when it is off.
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      fault_cnt++;
    end
  endfunction

  // Output side: checks each accepted range against the oldest prediction
  // and applies random stall bursts that do not depend on out_valid.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_ranges.size() == 0) begin
        $display("%0t ns: unexpected range, expected none actual %h", $time, out_word);
        fault_cnt++;
      end else begin
        want = pending_ranges.pop_front();
        check_field("action", 32'(want.action), 32'(out_word.action));
        check_field("guest_address", want.guest_address, out_word.guest_address);
        check_field("host_address", want.host_address, out_word.host_address);
        check_field("byte_length", want.byte_length, out_word.byte_length);
        check_field("rights", 32'(want.rights), 32'(out_word.rights));
        check_field("last", 32'(want.last), 32'(out_word.last));
      end
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    out_stall <= (stall_left != 0);
  end

  // Window moves under the reset configuration, where the guest base is
  // still zero so that both mapping kinds must answer with an error.
  task automatic test_window_adjust();
    send_word(adjust_word(32'h0001_0000, '1));          // commit top, bottom kept
    send_word(adjust_word(32'h0001_0000, '1));          // nothing changes
    send_word(adjust_word(32'h0000_3001, 32'h0000_1FFF)); // decommit top and bottom
    send_word(adjust_word('1, 32'h0000_0000));          // widest top, bottom back to 0
    send_word(adjust_word(32'h0000_0000, 32'hFFFF_FFFE)); // both ends cross
    send_word(bitmap_word(10'd3, 32'h0000_00F0, 1'b1)); // error, no base
    send_word(contig_word(1'b1));                       // error, no base
    send_word(adjust_word('1, '1) ^ {KIND_ADJUST ^ KIND_UNUSED, {($bits(in_word_t) - 2){1'b0}}});
    drain_block();
  endtask

  // Runs in bitmap words: empty, full, alternating and edge bits.
  task automatic test_bitmap_words();
    write_reg(REG_PAGE_SHIFT, 32'd12);
    write_reg(REG_PROCESS_BASE, 32'h4000_0000);
    write_reg(REG_HOST_BASE, 32'h8000_0000);
    write_reg(REG_RIGHTS, 32'd7);
    send_word(bitmap_word(10'd0, 32'h0000_0000, 1'b1));
    send_word(bitmap_word(10'd1023, 32'hFFFF_FFFF, 1'b1));
    send_word(bitmap_word(10'd5, 32'h5555_5555, 1'b0));
    send_word(bitmap_word(10'd0, 32'h8000_0001, 1'b1));
    send_word(bitmap_word(10'd1023, 32'h8000_0000, 1'b0));
    drain_block();
  endtask

  // Contiguous maps over a normal, an inverted and an empty window, with a
  // guest base close to the top of the address space so that sums wrap.
  task automatic test_contiguous();
    write_reg(REG_PROCESS_BASE, 32'hFFFF_F000);
    write_reg(REG_RIGHTS, 32'd0);
    send_word(adjust_word(32'h0002_0000, 32'h0000_8000));
    send_word(contig_word(1'b1));
    send_word(adjust_word(32'h0002_0000, 32'h0004_0000));
    send_word(contig_word(1'b0));
    send_word(adjust_word(32'h0004_0000, '1));
    send_word(contig_word(1'b1));
    drain_block();
  endtask

  // Page shifts below and above the legal band, and the band's top edge.
  task automatic test_shift_limits();
    write_reg(REG_PAGE_SHIFT, 32'd0);
    send_word(adjust_word(32'h1234_5678, 32'h0000_0400));
    send_word(bitmap_word(10'd7, 32'hFFFF_0000, 1'b1));
    drain_block();
    write_reg(REG_PAGE_SHIFT, 32'd31);
    send_word(adjust_word(32'hFFFF_0001, 32'h0001_FFFF));
    send_word(contig_word(1'b1));
    drain_block();
    write_reg(REG_PAGE_SHIFT, 32'd16);
    write_reg(REG_HOST_BASE, 32'hFFFF_FFFF);
    send_word(bitmap_word(10'd1000, 32'h0F0F_F0F0, 1'b1));
    drain_block();
  endtask

  function automatic logic [31:0] random_bitmap();
    case ($urandom_range(0, 5))
      0: return $urandom() & $urandom();
      1: return $urandom() | $urandom();
      2: return '1;
      3: return '0;
      4: return $urandom() & $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  // Byte addresses: often small so that the window stays in a sensible
  // range, sometimes all ones to exercise the keep-bottom case.
  function automatic logic [31:0] random_addr();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return $urandom() & 32'h00FF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.kind = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
    w.new_bottom = random_addr();
    w.new_top = random_addr();
    w.word_index = 10'($urandom_range(0, WordCount - 1));
    w.word_bits = random_bitmap();
    w.do_map = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Random traffic in four phases, each under a fresh configuration; the
  // last phase runs without gaps or stalls on either side.
  task automatic test_random_traffic();
    in_word_t    w;
    int unsigned counted;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_PAGE_SHIFT, $urandom_range(8, 18));
      write_reg(REG_PROCESS_BASE, ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom());
      write_reg(REG_HOST_BASE, $urandom());
      write_reg(REG_RIGHTS, $urandom_range(0, 7));
      idle_en = (phase != 3);
      counted = 0;
      while (counted < 19) begin
        w = random_word();
        send_word(w);
        if (w.kind != KIND_UNUSED) counted++;
      end
      drain_block();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_window_adjust();
    test_bitmap_words();
    test_contiguous();
    test_shift_limits();
    test_random_traffic();
    if (fault_cnt == 0) begin
      $display("[page_chunk_commit_and_map_runs_core] OK");
    end else begin
      $display("[page_chunk_commit_and_map_runs_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pccmr_pkg.sv
rtl/pccmr_ctrl.sv
rtl/pccmr_datapath.sv
rtl/page_chunk_commit_and_map_runs_core.sv
rtl/pccmr_checker.sv
tb/page_chunk_commit_and_map_runs_core_tb.sv
